[sv/emts_pkg.sv]
// Shared types, codes and calendar helpers for the encoder menu time setter.
package emts_pkg;

  // Field widths of one time stamp
  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;

  // Calendar constants
  localparam logic [11:0] YEAR_LOW   = 12'd2000;
  localparam logic [6:0]  HUNDRED    = 7'd100;
  // floor(v / 100) == (v * 1311) >> 17, exact for v below 4699
  localparam logic [10:0] RECIP_100  = 11'd1311;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Command codes
  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_OPEN   = 2'd1;
  localparam logic [1:0] CMD_DONE   = 2'd2;

  // Button events
  localparam logic [1:0] BTN_CLICK  = 2'd1;
  localparam logic [1:0] BTN_LONG   = 2'd2;

  // Action codes
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_SET    = 3'd1;
  localparam logic [2:0] ACT_EJECT  = 3'd2;
  localparam logic [2:0] ACT_ERASE  = 3'd3;
  localparam logic [2:0] ACT_CLOSE  = 3'd4;

  // Root menu entries
  localparam logic [1:0] ROOT_SET   = 2'd0;
  localparam logic [1:0] ROOT_EJECT = 2'd1;
  localparam logic [1:0] ROOT_ERASE = 2'd2;

  // Time edit field index
  localparam logic [2:0] FIELD_YEAR   = 3'd0;
  localparam logic [2:0] FIELD_MONTH  = 3'd1;
  localparam logic [2:0] FIELD_DAY    = 3'd2;
  localparam logic [2:0] FIELD_HOUR   = 3'd3;
  localparam logic [2:0] FIELD_MINUTE = 3'd4;
  localparam logic [2:0] FIELD_DONE   = 3'd5;

  typedef enum logic [1:0] {
    SCR_ROOT,
    SCR_TIME,
    SCR_CONFIRM,
    SCR_RESULT
  } screen_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } tstamp_t;

  // Request to the time edit unit
  typedef struct packed {
    logic [2:0]        field;
    logic signed [4:0] delta;
  } edit_req_t;

  typedef struct packed {
    logic [6:0] q;
    logic [6:0] r;
  } div100_t;

  typedef struct packed {
    logic [2:0] action;
    logic       menu_open;
    logic [1:0] screen;
    logic [1:0] highlighted;
    logic [2:0] edit_field;
    tstamp_t    tm;
  } res_t;

  // Quotient and remainder by 100 through a reciprocal multiply
  function automatic div100_t div100(input logic [12:0] v);
    logic [23:0] prod;
    div100_t     res;
    prod  = 24'(v) * 24'(RECIP_100);
    res.q = prod[23:17];
    res.r = 7'(v - 13'(res.q) * 13'(HUNDRED));
    return res;
  endfunction

  // Gregorian leap rule for any 12-bit year
  function automatic logic leap_year(input logic [11:0] y);
    div100_t d;
    d = div100({1'b0, y});
    return (y[1:0] == 2'b00) && ((d.r != 7'd0) || (d.q[1:0] == 2'b00));
  endfunction

  // Month length; a month outside 1..12 counts 31 days
  function automatic logic [4:0] month_days(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    if ((m == 4'd0) || (m > 4'd12)) begin
      len = 5'd31;
    end else if (m == 4'd2) begin
      len = leap ? 5'd29 : 5'd28;
    end else begin
      len = MONTH_LEN[4'(m - 4'd1)];
    end
    return len;
  endfunction

  // Pull a day into 1..last
  function automatic logic [4:0] clamp_day(input logic [4:0] day, input logic [4:0] last);
    logic [4:0] v;
    v = (day > last) ? last : day;
    if (v == 5'd0) begin
      v = 5'd1;
    end
    return v;
  endfunction

endpackage

[sv/emts_time_edit.sv]
// Time edit unit: wraps the selected time field by a signed step count.
module emts_time_edit (
  input  emts_pkg::edit_req_t req_i,
  input  emts_pkg::tstamp_t   time_i,
  output emts_pkg::tstamp_t   time_o
);
  import emts_pkg::*;

  logic signed [4:0] d;
  logic [12:0]       yr_sum;
  div100_t           yr_div;
  logic [11:0]       yr_new;
  logic              yr_leap;
  logic              cur_leap;
  logic signed [5:0] mon_t;
  logic [3:0]        mon_new;
  logic [4:0]        day_last;
  logic signed [6:0] last_s;
  logic signed [6:0] day_t;
  logic signed [6:0] hr_t;
  logic signed [7:0] min_t;

  assign d = req_i.delta;

  // Year: 2000 is a multiple of 100, so only the remainder of year + d matters
  assign yr_sum = 13'(time_i.year) + 13'(d) + 13'(HUNDRED);
  assign yr_div = div100(yr_sum);
  assign yr_new = YEAR_LOW + 12'(yr_div.r);
  // 2000 is a leap century, so every fourth year of the range is leap
  assign yr_leap = (yr_div.r[1:0] == 2'b00);

  assign cur_leap = leap_year(time_i.year);
  assign day_last = month_days(cur_leap, time_i.month);
  assign last_s   = $signed({2'b00, day_last});

  // Month: wrap within 1..12
  always_comb begin
    mon_t = $signed({2'b00, time_i.month}) + 6'(d) - 6'sd1;
    if (mon_t < 6'sd0) begin
      mon_t = mon_t + 6'sd24;
    end
    if (mon_t >= 6'sd24) begin
      mon_t = mon_t - 6'sd24;
    end else if (mon_t >= 6'sd12) begin
      mon_t = mon_t - 6'sd12;
    end
    mon_new = 4'(mon_t + 6'sd1);
  end

  // Day: wrap within 1..month length
  always_comb begin
    day_t = $signed({2'b00, time_i.day}) + 7'(d) - 7'sd1;
    if (day_t < 7'sd0) begin
      day_t = day_t + last_s;
    end else if (day_t >= last_s) begin
      day_t = day_t - last_s;
    end
  end

  // Hour and minute wrap
  always_comb begin
    hr_t = $signed({2'b00, time_i.hour}) + 7'(d);
    if (hr_t < 7'sd0) begin
      hr_t = hr_t + 7'sd24;
    end else if (hr_t >= 7'sd24) begin
      hr_t = hr_t - 7'sd24;
    end
    min_t = $signed({2'b00, time_i.minute}) + 8'(d);
    if (min_t < 8'sd0) begin
      min_t = min_t + 8'sd60;
    end else if (min_t >= 8'sd60) begin
      min_t = min_t - 8'sd60;
    end
  end

  // Select the edited field; year and month changes re-clamp the day
  always_comb begin
    time_o = time_i;
    case (req_i.field)
      FIELD_YEAR: begin
        time_o.year = yr_new;
        time_o.day  = clamp_day(time_i.day, month_days(yr_leap, time_i.month));
      end
      FIELD_MONTH: begin
        time_o.month = mon_new;
        time_o.day   = clamp_day(time_i.day, month_days(cur_leap, mon_new));
      end
      FIELD_DAY: begin
        time_o.day = 5'(day_t + 7'sd1);
      end
      FIELD_HOUR: begin
        time_o.hour = 5'(hr_t);
      end
      FIELD_MINUTE: begin
        time_o.minute = 6'(min_t);
      end
      default: begin
        time_o = time_i;
      end
    endcase
  end

endmodule

[sv/encoder_menu_time_setter.sv]
// Menu controller for a rotary encoder and push button, with time editing.
//
// Input channel (in_valid/in_ready): one word per event. in_cmd selects an
// update (encoder steps in in_detents and a button event), an open that
// copies the in_now_* clock time, or an action completed notice.
// Result channel (out_valid/out_ready): exactly one word per input word,
// in order, with the requested action, the menu screen and the edited time.
// No configuration.
//
// Each word is held in the input register, then passes the menu decode
// and calendar arithmetic into the result register that drives out_valid.
// One word is accepted every cycle while out_ready is high; the longest
// path is the divide-by-100 reciprocal multiply of the year wrap and
// leap test.
//
// Reset (rst_n low, synchronous) closes the menu, returns to the root
// entry and empties both registers. When the receiver holds out_ready low
// the result register keeps its word and the input register takes one
// more word, then in_ready drops until the result is taken.
module encoder_menu_time_setter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_cmd,
  input  logic signed [4:0] in_detents,
  input  logic [1:0]        in_button,
  input  logic [11:0]       in_now_year,
  input  logic [3:0]        in_now_month,
  input  logic [4:0]        in_now_day,
  input  logic [4:0]        in_now_hour,
  input  logic [5:0]        in_now_minute,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_action,
  output logic              out_menu_open,
  output logic [1:0]        out_screen,
  output logic [1:0]        out_highlighted,
  output logic [2:0]        out_edit_field,
  output logic [11:0]       out_year,
  output logic [3:0]        out_month,
  output logic [4:0]        out_day,
  output logic [4:0]        out_hour,
  output logic [5:0]        out_minute
);
  import emts_pkg::*;

  // Input register
  logic              s1_valid_r;
  logic [1:0]        s1_cmd_r;
  logic signed [4:0] s1_det_r;
  logic [1:0]        s1_btn_r;
  tstamp_t           s1_now_r;
  logic              s1_fire;

  // Menu state
  logic    open_r, open_nxt;
  screen_t screen_r, screen_nxt;
  logic [1:0] rc_r, rc_nxt;
  logic [2:0] field_r, field_nxt;
  logic    yes_r, yes_nxt;
  tstamp_t edit_r, edit_nxt;
  tstamp_t copy_r, copy_nxt;

  // Result register
  logic out_valid_r;
  res_t res_r, res_nxt;

  // Decode helpers
  edit_req_t  req;
  tstamp_t    edit_adj;
  tstamp_t    now_fix;
  logic       det_nz;
  logic [1:0] rc_sel;
  logic       yes_sel;
  logic [2:0] field_sel;
  logic [2:0] act;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || !out_valid_r || out_ready;

  // Take a word whenever the input register is free or drains this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r        <= in_cmd;
      s1_det_r        <= in_detents;
      s1_btn_r        <= in_button;
      s1_now_r.year   <= in_now_year;
      s1_now_r.month  <= in_now_month;
      s1_now_r.day    <= in_now_day;
      s1_now_r.hour   <= in_now_hour;
      s1_now_r.minute <= in_now_minute;
    end
  end

  // Field edit on the current time
  assign req.field = field_r;
  assign req.delta = s1_det_r;

  emts_time_edit u_time_edit (
    .req_i  (req),
    .time_i (edit_r),
    .time_o (edit_adj)
  );

  // Clock copy on open, with the day clamped to its month
  always_comb begin
    now_fix     = s1_now_r;
    now_fix.day = clamp_day(s1_now_r.day,
                            month_days(leap_year(s1_now_r.year), s1_now_r.month));
  end

  assign det_nz    = (s1_det_r != 5'sd0);
  assign rc_sel    = rc_r + s1_det_r[1:0];
  assign yes_sel   = yes_r ^ det_nz;
  assign field_sel = (field_r < FIELD_DONE) ? field_r + 3'd1 : field_r;

  // Next menu state and action
  always_comb begin
    open_nxt   = open_r;
    screen_nxt = screen_r;
    rc_nxt     = rc_r;
    field_nxt  = field_r;
    yes_nxt    = yes_r;
    edit_nxt   = edit_r;
    copy_nxt   = copy_r;
    act        = ACT_NONE;
    case (s1_cmd_r)
      CMD_UPDATE: begin
        if (open_r) begin
          if (s1_btn_r == BTN_LONG) begin
            if (screen_r == SCR_ROOT) begin
              open_nxt = 1'b0;
              act      = ACT_CLOSE;
            end else begin
              screen_nxt = SCR_ROOT;
              field_nxt  = FIELD_YEAR;
              yes_nxt    = 1'b0;
            end
          end else begin
            case (screen_r)
              SCR_ROOT: begin
                rc_nxt = rc_sel;
                if (s1_btn_r == BTN_CLICK) begin
                  case (rc_sel)
                    ROOT_SET: begin
                      edit_nxt   = copy_r;
                      screen_nxt = SCR_TIME;
                      field_nxt  = FIELD_YEAR;
                      yes_nxt    = 1'b0;
                    end
                    ROOT_EJECT: begin
                      act = ACT_EJECT;
                    end
                    ROOT_ERASE: begin
                      screen_nxt = SCR_CONFIRM;
                      field_nxt  = FIELD_YEAR;
                      yes_nxt    = 1'b0;
                    end
                    default: begin
                      open_nxt = 1'b0;
                      act      = ACT_CLOSE;
                    end
                  endcase
                end
              end
              SCR_TIME: begin
                if (det_nz) begin
                  edit_nxt = edit_adj;
                end
                if (s1_btn_r == BTN_CLICK) begin
                  field_nxt = field_sel;
                  if (field_sel >= FIELD_DONE) begin
                    copy_nxt = edit_nxt;
                    act      = ACT_SET;
                  end
                end
              end
              SCR_CONFIRM: begin
                yes_nxt = yes_sel;
                if (s1_btn_r == BTN_CLICK) begin
                  if (yes_sel) begin
                    act = ACT_ERASE;
                  end else begin
                    screen_nxt = SCR_ROOT;
                    field_nxt  = FIELD_YEAR;
                    yes_nxt    = 1'b0;
                  end
                end
              end
              default: begin
                if (s1_btn_r == BTN_CLICK) begin
                  screen_nxt = SCR_ROOT;
                  field_nxt  = FIELD_YEAR;
                  yes_nxt    = 1'b0;
                end
              end
            endcase
          end
        end
      end
      CMD_OPEN: begin
        open_nxt   = 1'b1;
        rc_nxt     = ROOT_SET;
        screen_nxt = SCR_ROOT;
        field_nxt  = FIELD_YEAR;
        yes_nxt    = 1'b0;
        edit_nxt   = now_fix;
        copy_nxt   = now_fix;
      end
      CMD_DONE: begin
        screen_nxt = SCR_RESULT;
      end
      default: begin
        act = ACT_NONE;
      end
    endcase

    // Build the result word; a closed menu shows only action and menu_open
    res_nxt           = '0;
    res_nxt.action    = act;
    res_nxt.menu_open = open_nxt;
    if (open_nxt) begin
      res_nxt.screen = screen_nxt;
      if (screen_nxt == SCR_ROOT) begin
        res_nxt.highlighted = rc_nxt;
      end else if (screen_nxt == SCR_CONFIRM) begin
        res_nxt.highlighted = {1'b0, yes_nxt};
      end
      if (screen_nxt == SCR_TIME) begin
        res_nxt.edit_field = field_nxt;
      end
      res_nxt.tm = edit_nxt;
    end
  end

  // Advance menu state as each word leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r   <= 1'b0;
      screen_r <= SCR_ROOT;
      rc_r     <= ROOT_SET;
      field_r  <= FIELD_YEAR;
      yes_r    <= 1'b0;
    end else if (s1_fire) begin
      open_r   <= open_nxt;
      screen_r <= screen_nxt;
      rc_r     <= rc_nxt;
      field_r  <= field_nxt;
      yes_r    <= yes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      edit_r <= edit_nxt;
      copy_r <= copy_nxt;
      res_r  <= res_nxt;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_action      = res_r.action;
  assign out_menu_open   = res_r.menu_open;
  assign out_screen      = res_r.screen;
  assign out_highlighted = res_r.highlighted;
  assign out_edit_field  = res_r.edit_field;
  assign out_year        = res_r.tm.year;
  assign out_month       = res_r.tm.month;
  assign out_day         = res_r.tm.day;
  assign out_hour        = res_r.tm.hour;
  assign out_minute      = res_r.tm.minute;

  // Field index never passes the done position
  a_field_sat: assert property (@(posedge clk) disable iff (!rst_n)
    field_r <= FIELD_DONE)
    else $error("field index beyond done");

  // A closed menu shows no screen details
  a_closed_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_menu_open |->
      out_screen == 2'd0 && out_highlighted == 2'd0 && out_edit_field == 3'd0)
    else $error("closed menu shows screen details");

  // Close action always leaves the menu closed
  a_close_shut: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_CLOSE |-> !out_menu_open)
    else $error("close action with menu open");

  // Set time only at the end of the field walk on the time screen
  a_set_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_SET |->
      out_screen == SCR_TIME && out_edit_field == FIELD_DONE)
    else $error("set time before last field");

  // An open menu never shows day zero
  a_day_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_menu_open |-> out_day != 5'd0)
    else $error("day of month is zero");

  // Back pressure reaches the input only with both registers full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r)
    else $error("input stalled with free register");

endmodule
